FILE: rtl/rcst_pkg.sv
// Shared types and codes for the reference-counted slot table.
// No dependencies; imported by refcounted_slot_table_core, not by rcst_slot_ram.
package rcst_pkg;

    localparam int CFG_BITS  = 6;
    localparam int KEY_W     = 32;
    localparam int SLOT_W    = 5;
    localparam int RUN_W     = 4;

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_GROUP   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ROOM  = 2'd1;
    localparam logic [1:0] ST_REL_ERR  = 2'd2;

    typedef struct packed {
        logic [1:0]        op;
        logic [KEY_W-1:0]  key;
        logic              group_end;
        logic [SLOT_W-1:0] first_slot;
        logic [RUN_W-1:0]  run_length;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
    } rsp_t;

endpackage

FILE: rtl/refcounted_slot_table_core.sv
// Reference-counted slot table, top level.
// Depends on rcst_pkg and rcst_slot_ram.
//
// Request channel (req_valid/req_stall/req) carries one op per transaction:
// add a key, stream one element of a group add, or release a run of slots.
// Response channel (rsp_valid/rsp_stall/rsp) returns at most one result per
// request; group elements without group_end and op 3 return none.
// cfg_valid/cfg_ready writes slot_limit; cfg_ready is always high.
// Requests are taken one at a time; req_stall stays high until the result
// of the current request has been loaded into the response register.
// Every table access is a registered read followed by a check or write, so
// a single add scans the filled slots until it finds its key, a release walks
// its run of slots, and a group add checks up to GROUP_MAX slots per tried
// base, over up to SLOTS bases, and then claims GROUP_MAX slots at most.
// A finished result waits in the response register while rsp_stall is high;
// the next request is accepted meanwhile, and its result waits until the
// register frees up.
// Reset empties the table (fill level zero), drops any pending group and
// sets slot_limit to 32. Table contents need no clearing.
module refcounted_slot_table_core
    import rcst_pkg::*;
#(
    parameter int SLOTS      = 32,
    parameter int GROUP_MAX  = 8,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  req_t                req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output rsp_t                rsp,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_BITS-1:0] cfg_data
);

    localparam int AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW  = $clog2(SLOTS + 1);
    localparam int PW  = ((CW > SLOT_W) ? CW : SLOT_W) + 1;
    localparam int GW  = $clog2(GROUP_MAX);
    localparam int GCW = $clog2(GROUP_MAX + 1);
    localparam int SW  = (GCW > RUN_W) ? GCW : RUN_W;

    typedef enum logic [3:0] {
        IDLE, SCAN_RD, SCAN_CK, DECIDE, BASE_TRY, G_RD, G_CK,
        C_RD, C_WR, R_RD, R_CK, FINISH
    } state_t;

    state_t                state_reg;
    logic [CFG_BITS-1:0]   limit_reg;
    logic [CW-1:0]         fill_reg;
    logic [GCW-1:0]        gsize_reg;
    logic                  gover_reg;
    logic [KEY_BITS-1:0]   gkeys_reg [GROUP_MAX];
    logic [KEY_BITS-1:0]   key_reg;
    logic [GCW-1:0]        n_reg;
    logic [PW-1:0]         base_reg;
    logic [SW-1:0]         step_reg;
    logic [RUN_W-1:0]      len_reg;
    logic                  bad_reg;
    logic                  zfound_reg;
    logic [PW-1:0]         zslot_reg;
    logic [1:0]            res_status_reg;
    logic [SLOT_W-1:0]     res_slot_reg;
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    logic [CW-1:0]         lim;
    logic [PW-1:0]         pos;
    logic [KEY_BITS-1:0]   in_key;
    logic [KEY_BITS-1:0]   gkey_cur;
    logic [COUNT_BITS-1:0] cnt_bump;
    logic [GCW-1:0]        n_new;
    logic                  rsp_load;

    logic                  rd_en;
    logic [KEY_BITS-1:0]   rd_key;
    logic [COUNT_BITS-1:0] rd_count;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [KEY_BITS-1:0]   wr_key;
    logic [COUNT_BITS-1:0] wr_count;

    // zero or out-of-range limit means the built size
    always_comb
    begin
        if (limit_reg == '0 || 32'(limit_reg) > 32'(SLOTS))
            lim = CW'(SLOTS);
        else
            lim = CW'(limit_reg);
    end

    assign pos      = base_reg + PW'(step_reg);
    assign in_key   = KEY_BITS'(req.key);
    assign gkey_cur = gkeys_reg[step_reg[GW-1:0]];
    assign cnt_bump = (rd_count == '1) ? rd_count : rd_count + 1'b1;
    assign n_new    = gsize_reg + 1'b1;
    assign rsp_load = (state_reg == FINISH) && (!rsp_valid_reg || !rsp_stall);

    assign req_stall = (state_reg != IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // table access control
    always_comb
    begin
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = pos[AW-1:0];
        wr_key   = rd_key;
        wr_count = cnt_bump;
        unique case (state_reg)
            SCAN_RD:  rd_en = (pos < PW'(fill_reg));
            SCAN_CK:  wr_en = (rd_key == key_reg);
            DECIDE:
            begin
                wr_key   = key_reg;
                wr_count = COUNT_BITS'(1);
                if (zfound_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = zslot_reg[AW-1:0];
                end
                else if (fill_reg < lim)
                begin
                    wr_en   = 1'b1;
                    wr_addr = fill_reg[AW-1:0];
                end
            end
            G_RD:     rd_en = (PW'(step_reg) != PW'(n_reg)) && (pos < PW'(fill_reg));
            C_RD:
            begin
                rd_en    = (PW'(step_reg) != PW'(n_reg)) && (pos < PW'(fill_reg));
                wr_en    = (PW'(step_reg) != PW'(n_reg)) && (pos >= PW'(fill_reg));
                wr_key   = gkey_cur;
                wr_count = COUNT_BITS'(1);
            end
            C_WR:
            begin
                wr_en = 1'b1;
                if (rd_key != gkey_cur)
                begin
                    wr_key   = gkey_cur;
                    wr_count = COUNT_BITS'(1);
                end
            end
            R_RD:     rd_en = (SW'(len_reg) != step_reg) && (pos < PW'(fill_reg));
            R_CK:
            begin
                wr_en    = (rd_count != '0);
                wr_count = rd_count - 1'b1;
            end
            default: ;
        endcase
    end

    rcst_slot_ram #(
        .DEPTH      (SLOTS),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS),
        .AW         (AW)
    ) u_ram (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (pos[AW-1:0]),
        .rd_key   (rd_key),
        .rd_count (rd_count),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_key   (wr_key),
        .wr_count (wr_count)
    );

    always_ff @(posedge clk)
    begin
        if (state_reg == IDLE && req_valid && req.op == OP_GROUP && gsize_reg < GCW'(GROUP_MAX))
            gkeys_reg[gsize_reg[GW-1:0]] <= in_key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            limit_reg      <= CFG_BITS'(32);
            fill_reg       <= '0;
            gsize_reg      <= '0;
            gover_reg      <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_reg        <= '0;
            key_reg        <= '0;
            n_reg          <= '0;
            base_reg       <= '0;
            step_reg       <= '0;
            len_reg        <= '0;
            bad_reg        <= 1'b0;
            zfound_reg     <= 1'b0;
            zslot_reg      <= '0;
            res_status_reg <= ST_OK;
            res_slot_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
                limit_reg <= cfg_data;
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (rsp_valid_reg && !rsp_stall)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                IDLE:
                begin
                    if (req_valid)
                    begin
                        step_reg   <= '0;
                        zfound_reg <= 1'b0;
                        bad_reg    <= 1'b0;
                        case (req.op)
                            OP_ADD:
                            begin
                                base_reg  <= '0;
                                key_reg   <= in_key;
                                state_reg <= SCAN_RD;
                            end
                            OP_RELEASE:
                            begin
                                base_reg  <= PW'(req.first_slot);
                                len_reg   <= req.run_length;
                                state_reg <= R_RD;
                            end
                            OP_GROUP:
                            begin
                                base_reg <= '0;
                                if (req.group_end)
                                begin
                                    gsize_reg <= '0;
                                    gover_reg <= 1'b0;
                                    n_reg     <= n_new;
                                    if (gover_reg || gsize_reg == GCW'(GROUP_MAX)
                                        || PW'(n_new) > PW'(lim))
                                    begin
                                        res_status_reg <= ST_NO_ROOM;
                                        res_slot_reg   <= '0;
                                        state_reg      <= FINISH;
                                    end
                                    else if (gsize_reg == '0)
                                    begin
                                        // group of one is a plain add
                                        key_reg   <= in_key;
                                        state_reg <= SCAN_RD;
                                    end
                                    else
                                        state_reg <= BASE_TRY;
                                end
                                else if (gsize_reg < GCW'(GROUP_MAX))
                                    gsize_reg <= n_new;
                                else
                                    gover_reg <= 1'b1;
                            end
                            default: ;
                        endcase
                    end
                end
                SCAN_RD:
                begin
                    if (pos < PW'(fill_reg))
                        state_reg <= SCAN_CK;
                    else
                        state_reg <= DECIDE;
                end
                SCAN_CK:
                begin
                    if (rd_key == key_reg)
                    begin
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= SLOT_W'(base_reg);
                        state_reg      <= FINISH;
                    end
                    else
                    begin
                        if (rd_count == '0 && !zfound_reg)
                        begin
                            zfound_reg <= 1'b1;
                            zslot_reg  <= base_reg;
                        end
                        base_reg  <= base_reg + 1'b1;
                        state_reg <= SCAN_RD;
                    end
                end
                DECIDE:
                begin
                    res_status_reg <= ST_OK;
                    state_reg      <= FINISH;
                    if (zfound_reg)
                        res_slot_reg <= SLOT_W'(zslot_reg);
                    else if (fill_reg < lim)
                    begin
                        res_slot_reg <= SLOT_W'(fill_reg);
                        fill_reg     <= fill_reg + 1'b1;
                    end
                    else
                    begin
                        res_status_reg <= ST_NO_ROOM;
                        res_slot_reg   <= '0;
                    end
                end
                BASE_TRY:
                begin
                    step_reg <= '0;
                    if (base_reg + PW'(n_reg) > PW'(lim))
                    begin
                        res_status_reg <= ST_NO_ROOM;
                        res_slot_reg   <= '0;
                        state_reg      <= FINISH;
                    end
                    else
                        state_reg <= G_RD;
                end
                G_RD:
                begin
                    if (PW'(step_reg) == PW'(n_reg))
                    begin
                        step_reg  <= '0;
                        state_reg <= C_RD;
                    end
                    else if (pos >= PW'(fill_reg))
                        step_reg <= step_reg + 1'b1;
                    else
                        state_reg <= G_CK;
                end
                G_CK:
                begin
                    if (rd_key == gkey_cur || rd_count == '0)
                    begin
                        step_reg  <= step_reg + 1'b1;
                        state_reg <= G_RD;
                    end
                    else
                    begin
                        base_reg  <= base_reg + 1'b1;
                        state_reg <= BASE_TRY;
                    end
                end
                C_RD:
                begin
                    if (PW'(step_reg) == PW'(n_reg))
                    begin
                        if (base_reg + PW'(n_reg) > PW'(fill_reg))
                            fill_reg <= CW'(base_reg + PW'(n_reg));
                        res_status_reg <= ST_OK;
                        res_slot_reg   <= SLOT_W'(base_reg);
                        state_reg      <= FINISH;
                    end
                    else if (pos >= PW'(fill_reg))
                        step_reg <= step_reg + 1'b1;
                    else
                        state_reg <= C_WR;
                end
                C_WR:
                begin
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= C_RD;
                end
                R_RD:
                begin
                    if (SW'(len_reg) == step_reg)
                    begin
                        res_status_reg <= bad_reg ? ST_REL_ERR : ST_OK;
                        res_slot_reg   <= SLOT_W'(base_reg);
                        state_reg      <= FINISH;
                    end
                    else if (pos >= PW'(fill_reg))
                    begin
                        bad_reg  <= 1'b1;
                        step_reg <= step_reg + 1'b1;
                    end
                    else
                        state_reg <= R_CK;
                end
                R_CK:
                begin
                    if (rd_count == '0)
                        bad_reg <= 1'b1;
                    step_reg  <= step_reg + 1'b1;
                    state_reg <= R_RD;
                end
                FINISH:
                begin
                    if (rsp_load)
                    begin
                        rsp_reg.status <= res_status_reg;
                        rsp_reg.slot   <= res_slot_reg;
                        state_reg      <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    // fill level never passes the built size
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(fill_reg) <= 32'(SLOTS))
        else $error("fill level above table size");

    // slots are never given back to the free tail
    a_fill_mono: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> fill_reg >= $past(fill_reg))
        else $error("fill level decreased");

    // table writes only from the check/claim/release states
    a_wr_state: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == SCAN_CK || state_reg == DECIDE || state_reg == C_RD
                   || state_reg == C_WR || state_reg == R_CK))
        else $error("table write outside an update state");

    // a result is only loaded when the response register is free
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |=> $stable(rsp_reg))
        else $error("pending response overwritten");

endmodule

FILE: rtl/rcst_slot_ram.sv
// Slot table storage: key and owner count per slot, one write port and one
// read port with registered read data. Depends on nothing.
module rcst_slot_ram #(
    parameter int DEPTH      = 32,
    parameter int KEY_BITS   = 32,
    parameter int COUNT_BITS = 16,
    parameter int AW         = 5
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output logic [KEY_BITS-1:0]   rd_key,
    output logic [COUNT_BITS-1:0] rd_count,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  logic [KEY_BITS-1:0]   wr_key,
    input  logic [COUNT_BITS-1:0] wr_count
);

    logic [KEY_BITS-1:0]   key_mem   [DEPTH];
    logic [COUNT_BITS-1:0] count_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr]   <= wr_key;
            count_mem[wr_addr] <= wr_count;
        end
        if (rd_en)
        begin
            rd_key   <= key_mem[rd_addr];
            rd_count <= count_mem[rd_addr];
        end
    end

endmodule

FILE: tb/sv/refcounted_slot_table_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for refcounted_slot_table_core: directed table, then random traffic.
// Depends on rcst_pkg and the RTL of the slot table; needs no files or arguments.
module refcounted_slot_table_core_tb;
    import rcst_pkg::*;

    localparam int NSLOT = 32;
    localparam int NGRP  = 8;
    localparam int CMAX  = 65535;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_BITS-1:0] cfg_data;

    refcounted_slot_table_core dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [31:0] tbl_key [NSLOT];
    int          tbl_cnt [NSLOT];
    int          fill;
    logic [31:0] grp_key [NGRP];
    int          grp_n;
    bit          grp_over;
    int          lim_reg;

    rsp_t expected_rsp [$];
    int   mismatches;
    int   n_rsp;
    int   n_req;
    int   send_idle_pct;
    int   stall_pct;

    typedef struct {
        req_t r;
        bit   fixed;
        rsp_t want;
    } row_t;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    function automatic int limit_now();
        if (lim_reg == 0 || lim_reg > NSLOT)
            return NSLOT;
        return lim_reg;
    endfunction

    function automatic rsp_t mk(logic [1:0] s, int sl);
        rsp_t x;
        x.status = s;
        x.slot = sl[4:0];
        return x;
    endfunction

    function automatic rsp_t add_key(logic [31:0] k);
        for (int i = 0; i < fill; i++)
            if (tbl_key[i] == k)
            begin
                if (tbl_cnt[i] < CMAX)
                    tbl_cnt[i]++;
                return mk(ST_OK, i);
            end
        for (int i = 0; i < fill; i++)
            if (tbl_cnt[i] == 0)
            begin
                tbl_key[i] = k;
                tbl_cnt[i] = 1;
                return mk(ST_OK, i);
            end
        if (fill < limit_now())
        begin
            tbl_key[fill] = k;
            tbl_cnt[fill] = 1;
            fill++;
            return mk(ST_OK, fill - 1);
        end
        return mk(ST_NO_ROOM, 0);
    endfunction

    function automatic rsp_t claim_group();
        int  lim;
        int  p;
        bit  fits;
        lim = limit_now();
        if (grp_n == 1)
            return add_key(grp_key[0]);
        if (grp_n > lim)
            return mk(ST_NO_ROOM, 0);
        for (int b = 0; b + grp_n <= lim; b++)
        begin
            fits = 1;
            for (int i = 0; i < grp_n; i++)
            begin
                p = b + i;
                if (p < fill && tbl_key[p] != grp_key[i] && tbl_cnt[p] != 0)
                    fits = 0;
            end
            if (fits)
            begin
                for (int i = 0; i < grp_n; i++)
                begin
                    p = b + i;
                    if (p < fill && tbl_key[p] == grp_key[i])
                    begin
                        if (tbl_cnt[p] < CMAX)
                            tbl_cnt[p]++;
                    end
                    else
                    begin
                        tbl_key[p] = grp_key[i];
                        tbl_cnt[p] = 1;
                    end
                end
                if (b + grp_n > fill)
                    fill = b + grp_n;
                return mk(ST_OK, b);
            end
        end
        return mk(ST_NO_ROOM, 0);
    endfunction

    // returns 1 when the request produces a result
    function automatic bit predict_slot_table(req_t r, output rsp_t res);
        bit bad;
        int p;
        res = mk(ST_OK, 0);
        case (r.op)
            OP_ADD:
            begin
                res = add_key(r.key);
                return 1;
            end
            OP_RELEASE:
            begin
                bad = 0;
                for (int i = 0; i < r.run_length; i++)
                begin
                    p = r.first_slot + i;
                    if (p >= fill || p >= NSLOT || tbl_cnt[p] == 0)
                        bad = 1;
                    else
                        tbl_cnt[p]--;
                end
                res = mk(bad ? ST_REL_ERR : ST_OK, r.first_slot);
                return 1;
            end
            OP_GROUP:
            begin
                if (grp_n < NGRP)
                begin
                    grp_key[grp_n] = r.key;
                    grp_n++;
                end
                else
                    grp_over = 1;
                if (!r.group_end)
                    return 0;
                if (grp_over)
                    res = mk(ST_NO_ROOM, 0);
                else
                    res = claim_group();
                grp_n = 0;
                grp_over = 0;
                return 1;
            end
            default:
                return 0;
        endcase
    endfunction

    // valid stays high after the transaction; the next call replaces the request or drops valid, and drain() drops it
    task automatic send_req(req_t r, bit fixed, rsp_t want);
        rsp_t res;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        n_req++;
        if (predict_slot_table(r, res))
        begin
            if (fixed && res != want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("table row disagrees with predictor: %p vs %p", want, res);
            end
            expected_rsp.push_back(fixed ? want : res);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                n_rsp++;
                if (expected_rsp.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected response status=%0d slot=%0d",
                                 rsp.status, rsp.slot);
                end
                else
                begin
                    if (rsp.status !== expected_rsp[0].status
                        || rsp.slot !== expected_rsp[0].slot)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected status=%0d slot=%0d, got %0d/%0d",
                                     expected_rsp[0].status, expected_rsp[0].slot,
                                     rsp.status, rsp.slot);
                    end
                    void'(expected_rsp.pop_front());
                end
            end
            rsp_stall <= (stall_pct > 0 && $urandom_range(99) < stall_pct);
        end
    end

    task automatic drain();
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        // a pending group element may still be in flight with no result
        repeat (600) @(posedge clk);
    endtask

    task automatic write_limit(int v);
        cfg_valid <= 1'b1;
        cfg_data <= v[CFG_BITS-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        lim_reg = v;
    endtask

    function automatic req_t mkreq(logic [1:0] op, logic [31:0] k, bit ge, int fs, int rl);
        req_t r;
        r.op = op;
        r.key = k;
        r.group_end = ge;
        r.first_slot = fs[4:0];
        r.run_length = rl[3:0];
        return r;
    endfunction

    // pool keys make matches likely; sometimes a fully random key
    function automatic logic [31:0] pick_key();
        if ($urandom_range(9) == 0)
            return $urandom;
        return 32'(($urandom_range(11) * 32'h1111_1111) ^ {$urandom_range(1), 31'd0});
    endfunction

    task automatic random_phase(int items);
        int op_sel;
        int gl;
        for (int n = 0; n < items; )
        begin
            op_sel = $urandom_range(99);
            if (op_sel < 40)
            begin
                send_req(mkreq(OP_ADD, pick_key(), $urandom_range(1),
                               $urandom_range(31), $urandom_range(15)), 0, '0);
                n++;
            end
            else if (op_sel < 65)
            begin
                gl = ($urandom_range(19) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 4);
                for (int i = 0; i < gl; i++)
                    send_req(mkreq(OP_GROUP, pick_key(), i == gl - 1,
                                   $urandom_range(31), $urandom_range(15)), 0, '0);
                n += gl;
            end
            else if (op_sel < 95)
            begin
                send_req(mkreq(OP_RELEASE, $urandom, $urandom_range(1),
                               (fill > 0 && $urandom_range(3) != 0) ?
                                   $urandom_range(fill - 1) : $urandom_range(31),
                               $urandom_range(3) == 0 ? $urandom_range(15)
                                                      : $urandom_range(1, 3)), 0, '0);
                n++;
            end
            else
                send_req(mkreq(2'd3, $urandom, $urandom_range(1),
                               $urandom_range(31), $urandom_range(15)), 0, '0);
        end
    endtask

    row_t rows [$];

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        mismatches = 0;
        n_rsp = 0;
        n_req = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        fill = 0;
        grp_n = 0;
        grp_over = 0;
        lim_reg = 32;
        for (int i = 0; i < NSLOT; i++)
        begin
            tbl_key[i] = '0;
            tbl_cnt[i] = 0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: fixed results where they are obvious
        rows.push_back('{mkreq(OP_RELEASE, 0, 0, 0, 1), 1, mk(ST_REL_ERR, 0)});
        rows.push_back('{mkreq(OP_ADD, 32'h0, 0, 0, 0), 1, mk(ST_OK, 0)});
        rows.push_back('{mkreq(OP_ADD, 32'hFFFF_FFFF, 1, 31, 15), 1, mk(ST_OK, 1)});
        rows.push_back('{mkreq(OP_ADD, 32'h0, 0, 0, 0), 1, mk(ST_OK, 0)});
        rows.push_back('{mkreq(2'd3, 32'hFFFF_FFFF, 1, 31, 15), 0, '0});
        rows.push_back('{mkreq(OP_RELEASE, 0, 0, 0, 2), 1, mk(ST_OK, 0)});
        rows.push_back('{mkreq(OP_RELEASE, 0, 0, 1, 1), 1, mk(ST_REL_ERR, 1)});
        rows.push_back('{mkreq(OP_ADD, 32'hFFFF_FFFF, 0, 0, 0), 0, '0});
        rows.push_back('{mkreq(OP_RELEASE, 0, 0, 31, 15), 1, mk(ST_REL_ERR, 31)});
        rows.push_back('{mkreq(OP_RELEASE, 0, 0, 0, 0), 1, mk(ST_OK, 0)});
        rows.push_back('{mkreq(OP_GROUP, 32'hA5A5_0001, 1, 0, 0), 0, '0});
        rows.push_back('{mkreq(OP_GROUP, 32'h1, 0, 0, 0), 0, '0});
        rows.push_back('{mkreq(OP_ADD, 32'h7, 0, 0, 0), 0, '0});
        rows.push_back('{mkreq(OP_GROUP, 32'h2, 0, 0, 0), 0, '0});
        rows.push_back('{mkreq(OP_GROUP, 32'h3, 1, 0, 0), 0, '0});
        for (int i = 0; i < 10; i++)
            rows.push_back('{mkreq(OP_GROUP, 32'(i), i == 9, 0, 0), 1,
                             mk(ST_NO_ROOM, 0)});
        foreach (rows[i])
            send_req(rows[i].r, rows[i].fixed, rows[i].want);
        drain();

        // limit 1: groups larger than the limit fail
        write_limit(1);
        send_req(mkreq(OP_GROUP, 32'h5, 0, 0, 0), 0, '0);
        send_req(mkreq(OP_GROUP, 32'h6, 1, 0, 0), 1, mk(ST_NO_ROOM, 0));
        random_phase(200);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 70; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 70; end
                3: begin send_idle_pct = 22; stall_pct = 22; end
                default: begin send_idle_pct = 0; stall_pct = 0; end
            endcase
            write_limit(ph == 0 ? 32 : ph == 1 ? 4 : ph == 2 ? 0 :
                        ph == 3 ? 63 : ph == 4 ? 2 : 17);
            random_phase(270);
            drain();
        end
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (100) @(posedge clk);

        $display("Ran %0d requests, %0d responses checked, limits from 0 to 63 under stalls.",
                 n_req, n_rsp);
        if (mismatches == 0 && expected_rsp.size() == 0)
            $display("** refcounted_slot_table_core: PASSED **");
        else
            $display("** refcounted_slot_table_core: FAILED **");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("timeout");
        $display("** refcounted_slot_table_core: FAILED **");
        $finish;
    end

endmodule
